@@ sv/glc_pkg.sv @@
// ----------------------------------------------------------------------------
// glc_pkg
// Shared types and constants for the graphic LCD controller.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int unsigned DEF_PAGES   = 8;
  localparam int unsigned DEF_COLUMNS = 132;

  localparam int unsigned PAGE_W = 4;
  localparam int unsigned COL_W  = 8;

  // bus access kinds
  localparam logic [1:0] OP_WR_CMD  = 2'd0;
  localparam logic [1:0] OP_WR_DATA = 2'd1;
  localparam logic [1:0] OP_RD_DATA = 2'd2;
  localparam logic [1:0] OP_RD_STAT = 2'd3;

  // command bytes; CMD_VOLUME takes the next command byte as contrast
  localparam logic [7:0] CMD_VOLUME   = 8'h81;
  localparam logic [7:0] CMD_SEG_NORM = 8'hA0;
  localparam logic [7:0] CMD_SEG_REV  = 8'hA1;
  localparam logic [7:0] CMD_BIAS_9   = 8'hA2;
  localparam logic [7:0] CMD_BIAS_7   = 8'hA3;
  localparam logic [7:0] CMD_ALL_OFF  = 8'hA4;
  localparam logic [7:0] CMD_ALL_ON   = 8'hA5;
  localparam logic [7:0] CMD_INV_OFF  = 8'hA6;
  localparam logic [7:0] CMD_INV_ON   = 8'hA7;
  localparam logic [7:0] CMD_DISP_OFF = 8'hAE;
  localparam logic [7:0] CMD_DISP_ON  = 8'hAF;
  localparam logic [7:0] CMD_RMW      = 8'hE0;
  localparam logic [7:0] CMD_RMW_END  = 8'hEE;
  localparam logic [7:0] CMD_RESET    = 8'hE2;

  // mode flag bit positions
  localparam int unsigned MF_ON   = 0;
  localparam int unsigned MF_INV  = 1;
  localparam int unsigned MF_ALL  = 2;
  localparam int unsigned MF_SEG  = 3;
  localparam int unsigned MF_COM  = 4;
  localparam int unsigned MF_BIAS = 5;

  localparam int unsigned OUT_W = 32;

  // controller to datapath commands
  typedef struct packed {
    logic latch;   // capture access, read RAM at current pointers
    logic commit;  // apply access, load result register
  } glc_ctl_t;

endpackage

@@ sv/glc_ctrl.sv @@
// ----------------------------------------------------------------------------
// glc_ctrl
// Sequencer: takes one bus access, commits it once the result slot is free.
// ----------------------------------------------------------------------------
module glc_ctrl
  import glc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output glc_ctl_t ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o.latch  = in_valid_i && (state_q == S_IDLE);
    ctl_o.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (ctl_o.latch) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (ctl_o.commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/glc_datapath.sv @@
// ----------------------------------------------------------------------------
// glc_datapath
// Display RAM, pointers, mode registers, command decode and result register.
// ----------------------------------------------------------------------------
module glc_datapath
  import glc_pkg::*;
#(
  parameter int unsigned PAGES   = DEF_PAGES,
  parameter int unsigned COLUMNS = DEF_COLUMNS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  glc_ctl_t         ctl_i,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       data_byte_i,
  output logic [OUT_W-1:0] result_o
);

  localparam int unsigned DEPTH  = PAGES * COLUMNS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  logic [1:0]        op_q;
  logic [7:0]        byte_q;
  logic [7:0]        rd_q;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [COL_W-1:0]  saved_q, saved_d;
  logic              rmw_q, rmw_d;
  logic              vol_q, vol_d;
  logic [5:0]        flags_q, flags_d;
  logic [5:0]        sl_q, sl_d;
  logic [5:0]        ct_q, ct_d;
  logic [5:0]        pr_q, pr_d;
  logic [OUT_W-1:0]  result_q;
  logic [7:0]        rd_data;

  logic              col_ok, page_ok, addr_ok, col_can_inc, ram_we;
  logic [ADDR_W-1:0] addr;

  assign col_ok      = ({1'b0, col_q} < 9'(COLUMNS));
  assign page_ok     = ({1'b0, page_q} < 5'(PAGES));
  assign addr_ok     = col_ok && page_ok;
  assign col_can_inc = (({1'b0, col_q} + 9'd1) < 9'(COLUMNS));
  assign addr        = ADDR_W'(32'(page_q) * 32'(COLUMNS) + 32'(col_q));
  assign ram_we      = ctl_i.commit && (op_q == OP_WR_DATA) && addr_ok;

  always_comb begin
    page_d  = page_q;
    col_d   = col_q;
    saved_d = saved_q;
    rmw_d   = rmw_q;
    vol_d   = vol_q;
    flags_d = flags_q;
    sl_d    = sl_q;
    ct_d    = ct_q;
    pr_d    = pr_q;
    rd_data = 8'h00;
    case (op_q)
      OP_WR_CMD: begin
        if (vol_q) begin
          ct_d  = byte_q[5:0];
          vol_d = 1'b0;
        end else if (byte_q inside {[8'h00:8'h0F]}) begin
          col_d = {col_q[7:4], byte_q[3:0]};
        end else if (byte_q inside {[8'h10:8'h1F]}) begin
          col_d = {byte_q[3:0], col_q[3:0]};
        end else if (byte_q inside {[8'h20:8'h27]}) begin
          pr_d = {byte_q[2:0], pr_q[2:0]};
        end else if (byte_q inside {[8'h28:8'h2F]}) begin
          pr_d = {pr_q[5:3], byte_q[2:0]};
        end else if (byte_q inside {[8'h40:8'h7F]}) begin
          sl_d = byte_q[5:0];
        end else if (byte_q inside {[8'hB0:8'hBF]}) begin
          page_d = byte_q[3:0];
        end else if (byte_q inside {[8'hC0:8'hCF]}) begin
          flags_d[MF_COM] = byte_q[3];
        end else begin
          case (byte_q)
            CMD_VOLUME:   vol_d = 1'b1;
            CMD_SEG_NORM: flags_d[MF_SEG]  = 1'b0;
            CMD_SEG_REV:  flags_d[MF_SEG]  = 1'b1;
            CMD_BIAS_9:   flags_d[MF_BIAS] = 1'b0;
            CMD_BIAS_7:   flags_d[MF_BIAS] = 1'b1;
            CMD_ALL_OFF:  flags_d[MF_ALL]  = 1'b0;
            CMD_ALL_ON:   flags_d[MF_ALL]  = 1'b1;
            CMD_INV_OFF:  flags_d[MF_INV]  = 1'b0;
            CMD_INV_ON:   flags_d[MF_INV]  = 1'b1;
            CMD_DISP_OFF: flags_d[MF_ON]   = 1'b0;
            CMD_DISP_ON:  flags_d[MF_ON]   = 1'b1;
            CMD_RMW: begin
              saved_d = col_q;
              rmw_d   = 1'b1;
            end
            CMD_RMW_END: begin
              if (rmw_q) begin
                col_d = saved_q;
                rmw_d = 1'b0;
              end
            end
            CMD_RESET: begin
              page_d  = '0;
              col_d   = '0;
              saved_d = '0;
              rmw_d   = 1'b0;
              vol_d   = 1'b0;
              flags_d = '0;
              sl_d    = '0;
              ct_d    = '0;
              pr_d    = '0;
            end
            default: ;
          endcase
        end
      end
      OP_WR_DATA: begin
        if (col_ok && col_can_inc) col_d = col_q + 8'd1;
      end
      OP_RD_DATA: begin
        if (addr_ok) rd_data = rd_q;
        if (col_ok && !rmw_q && col_can_inc) col_d = col_q + 8'd1;
      end
      OP_RD_STAT: begin
        rd_data = {1'b0, !flags_q[MF_SEG], !flags_q[MF_ON], 5'b0};
      end
      default: ;
    endcase
  end

  // RAM: read at capture, write at commit; pointers do not move in between
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) rd_q <= mem[addr];
    if (ram_we) mem[addr] <= byte_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q   <= opcode_i;
      byte_q <= data_byte_i;
    end
    if (ctl_i.commit) begin
      result_q <= {flags_d[MF_BIAS], pr_d[5:3], pr_d[2:0], flags_d[MF_COM],
                   flags_d[MF_SEG], ct_d, sl_d, flags_d[MF_ALL], flags_d[MF_INV],
                   flags_d[MF_ON], rd_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      col_q   <= '0;
      saved_q <= '0;
      rmw_q   <= 1'b0;
      vol_q   <= 1'b0;
      flags_q <= '0;
      sl_q    <= '0;
      ct_q    <= '0;
      pr_q    <= '0;
    end else if (ctl_i.commit) begin
      page_q  <= page_d;
      col_q   <= col_d;
      saved_q <= saved_d;
      rmw_q   <= rmw_d;
      vol_q   <= vol_d;
      flags_q <= flags_d;
      sl_q    <= sl_d;
      ct_q    <= ct_d;
      pr_q    <= pr_d;
    end
  end

  assign result_o = result_q;

endmodule

@@ sv/graphic_lcd_controller.sv @@
// ----------------------------------------------------------------------------
// graphic_lcd_controller
// Page-addressed monochrome LCD controller, one bus access per transfer.
// ----------------------------------------------------------------------------
// Result: an access is captured in S_IDLE, then committed in S_EXEC into the
// output register; commit waits while an earlier result still waits there.
// Accesses do not overlap: a new one is taken only once the last is committed;
// the single RAM port reads on capture and writes on commit of the same access.
// Reset: asynchronous, clears pointers, mode registers and handshake state;
// display RAM is not cleared and holds garbage until written.
module graphic_lcd_controller
  import glc_pkg::*;
#(
  parameter int unsigned PAGES   = DEF_PAGES,
  parameter int unsigned COLUMNS = DEF_COLUMNS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]       s_axis_tuser,  // [1:0] opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [7:0] read_data, [8] display_on, [9] inverted, [10] all_points_on,
  // [16:11] start_line, [22:17] contrast, [23] seg_reversed, [24] com_reversed,
  // [27:25] power_control, [30:28] resistor_ratio, [31] bias_select
  output logic [OUT_W-1:0] m_axis_tdata
);

  glc_ctl_t ctl;

  glc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  glc_datapath #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .opcode_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .result_o    (m_axis_tdata)
  );

  // one access in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an access is in flight");

  // commit only into a free or draining result slot
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before transfer");

  // a new result only follows an access under execution
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an access");

endmodule
